// ===== sv/clipseg_pkg.sv =====
package clipseg_pkg;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_MIN = 2'd0,
        REG_X_MAX = 2'd1,
        REG_Y_MIN = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_INSIDE   = 2'd0,
        ST_CLIPPED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_FAULT    = 2'd3
    } status_t;

    // Window edges, in test order; the first two are vertical.
    localparam int NUM_EDGES  = 4;
    localparam int EDGE_LEFT  = 0;
    localparam int EDGE_RIGHT = 1;
    localparam int EDGE_TOP   = 2;
    localparam int EDGE_BOT   = 3;

endpackage

// ===== sv/clipseg_seg_if.sv =====
interface clipseg_seg_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== sv/clipseg_res_if.sv =====
interface clipseg_res_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_start_x;
    logic signed [W-1:0] out_start_y;
    logic signed [W-1:0] out_end_x;
    logic signed [W-1:0] out_end_y;
    logic [1:0]          status;

    modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y, status,
                    input ready);
    modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y, status,
                  output ready);
endinterface

// ===== sv/clip_segment_to_rectangle.sv =====
// Channel   Direction  Payload
// segment   in         start_x, start_y, end_x, end_y
// clipped   out        out_start_x, out_start_y, out_end_x, out_end_y, status
// wr_*      in         wr_index, wr_data (window registers)
//
// One item per cycle while clipped.ready does not stall it; items pass stages A to D,
// the restoring divider (one quotient bit per stage) and the output register.
// rst_n clears all valid bits and loads the window 0..1023 in both axes.
// A stage holds only while it is full and the stage after it holds, so bubbles
// close up and a new item enters while a finished one waits at the output register.
module clip_segment_to_rectangle #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    clipseg_seg_if.sink                            segment,
    clipseg_res_if.source                          clipped,
    input  logic                                   wr_en,
    input  logic [clipseg_pkg::CFG_IDX_BITS-1:0]   wr_index,
    input  logic [COORD_BITS-1:0]                  wr_data
);

    localparam int N  = COORD_BITS;
    localparam int W1 = N + 1;
    localparam int PW = 2 * N + 2;
    localparam int NW = 2 * N + 3;
    localparam int Q  = N + 1;
    localparam int L  = Q + 5;
    localparam int NE = clipseg_pkg::NUM_EDGES;

    typedef struct packed {
        logic [N-1:0]             sx0;
        logic [N-1:0]             sy0;
        logic [N-1:0]             sx1;
        logic [N-1:0]             sy1;
        clipseg_pkg::status_t     status;
        logic                     one_cross;
        logic                     use_end;
        logic [1:0]               vert;
        logic [1:0]               neg;
        logic [1:0][N-1:0]        cval;
        logic [1:0][W1-1:0]       dsr;
        logic [1:0][W1-1:0]       quo;
        logic [1:0][NW-1:0]       rem;
    } dv_t;

    // window registers
    logic signed [N-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= N'(1023);
            y_min_reg <= '0;
            y_max_reg <= N'(1023);
        end
        else if (wr_en)
        begin
            case (wr_index)
                clipseg_pkg::REG_X_MIN: x_min_reg <= wr_data;
                clipseg_pkg::REG_X_MAX: x_max_reg <= wr_data;
                clipseg_pkg::REG_Y_MIN: y_min_reg <= wr_data;
                clipseg_pkg::REG_Y_MAX: y_max_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // valid chain
    logic [L-1:0] vld_reg;
    logic [L-1:0] adv;

    always_comb
    begin
        adv[L-1] = !vld_reg[L-1] || clipped.ready;
        for (int k = L - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= segment.valid;
            for (int k = 1; k < L; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign segment.ready = adv[0];

    // stage A: compares and differences
    logic signed [N-1:0] e_px [NE];
    logic signed [N-1:0] e_py [NE];
    logic signed [N-1:0] e_qx [NE];
    logic signed [N-1:0] e_qy [NE];
    logic                a_rej_next, a_in0_next, a_inb_next, a_in1;

    always_comb
    begin
        e_px[clipseg_pkg::EDGE_LEFT]  = x_min_reg;
        e_py[clipseg_pkg::EDGE_LEFT]  = y_min_reg;
        e_qx[clipseg_pkg::EDGE_LEFT]  = x_min_reg;
        e_qy[clipseg_pkg::EDGE_LEFT]  = y_max_reg;
        e_px[clipseg_pkg::EDGE_RIGHT] = x_max_reg;
        e_py[clipseg_pkg::EDGE_RIGHT] = y_min_reg;
        e_qx[clipseg_pkg::EDGE_RIGHT] = x_max_reg;
        e_qy[clipseg_pkg::EDGE_RIGHT] = y_max_reg;
        e_px[clipseg_pkg::EDGE_TOP]   = x_min_reg;
        e_py[clipseg_pkg::EDGE_TOP]   = y_min_reg;
        e_qx[clipseg_pkg::EDGE_TOP]   = x_max_reg;
        e_qy[clipseg_pkg::EDGE_TOP]   = y_min_reg;
        e_px[clipseg_pkg::EDGE_BOT]   = x_min_reg;
        e_py[clipseg_pkg::EDGE_BOT]   = y_max_reg;
        e_qx[clipseg_pkg::EDGE_BOT]   = x_max_reg;
        e_qy[clipseg_pkg::EDGE_BOT]   = y_max_reg;

        a_rej_next = (segment.start_x <= x_min_reg && segment.end_x <= x_min_reg) ||
                     (segment.start_x >= x_max_reg && segment.end_x >= x_max_reg) ||
                     (segment.start_y <= y_min_reg && segment.end_y <= y_min_reg) ||
                     (segment.start_y >= y_max_reg && segment.end_y >= y_max_reg);
        a_in0_next = segment.start_x > x_min_reg && segment.start_x < x_max_reg &&
                     segment.start_y > y_min_reg && segment.start_y < y_max_reg;
        a_in1      = segment.end_x > x_min_reg && segment.end_x < x_max_reg &&
                     segment.end_y > y_min_reg && segment.end_y < y_max_reg;
        a_inb_next = a_in0_next && a_in1;
    end

    logic signed [N-1:0]  a_s_reg [4];
    logic                 a_rej_reg, a_in0_reg, a_inb_reg;
    logic signed [W1-1:0] a_a1_reg, a_b1_reg;
    logic signed [W1-1:0] a_dpx_reg [NE];
    logic signed [W1-1:0] a_dpy_reg [NE];
    logic signed [W1-1:0] a_dqx_reg [NE];
    logic signed [W1-1:0] a_dqy_reg [NE];
    logic signed [W1-1:0] a_ea_reg  [NE];
    logic signed [W1-1:0] a_eb_reg  [NE];
    logic signed [W1-1:0] a_t1x_reg [NE];
    logic signed [W1-1:0] a_t1y_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_s_reg[0] <= segment.start_x;
            a_s_reg[1] <= segment.start_y;
            a_s_reg[2] <= segment.end_x;
            a_s_reg[3] <= segment.end_y;
            a_rej_reg  <= a_rej_next;
            a_in0_reg  <= a_in0_next;
            a_inb_reg  <= a_inb_next;
            a_a1_reg   <= W1'(segment.end_x) - W1'(segment.start_x);
            a_b1_reg   <= W1'(segment.start_y) - W1'(segment.end_y);
            for (int i = 0; i < NE; i++)
            begin
                a_dpx_reg[i] <= W1'(e_px[i]) - W1'(segment.start_x);
                a_dpy_reg[i] <= W1'(segment.start_y) - W1'(e_py[i]);
                a_dqx_reg[i] <= W1'(e_qx[i]) - W1'(segment.start_x);
                a_dqy_reg[i] <= W1'(segment.start_y) - W1'(e_qy[i]);
                a_ea_reg[i]  <= W1'(e_qx[i]) - W1'(e_px[i]);
                a_eb_reg[i]  <= W1'(e_py[i]) - W1'(e_qy[i]);
                a_t1x_reg[i] <= W1'(segment.end_x) - W1'(e_px[i]);
                a_t1y_reg[i] <= W1'(e_py[i]) - W1'(segment.end_y);
            end
        end
    end

    // stage B: products
    logic signed [N-1:0]  b_s_reg [4];
    logic                 b_rej_reg, b_in0_reg, b_inb_reg;
    logic signed [W1-1:0] b_a1_reg, b_b1_reg;
    logic signed [PW-1:0] b_m_reg [NE][8];
    logic signed [PW-1:0] b_cm_reg [NE];
    logic signed [PW-1:0] b_p12_reg, b_p03_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            b_s_reg   <= a_s_reg;
            b_rej_reg <= a_rej_reg;
            b_in0_reg <= a_in0_reg;
            b_inb_reg <= a_inb_reg;
            b_a1_reg  <= a_a1_reg;
            b_b1_reg  <= a_b1_reg;
            b_p12_reg <= PW'(a_s_reg[1]) * PW'(a_s_reg[2]);
            b_p03_reg <= PW'(a_s_reg[0]) * PW'(a_s_reg[3]);
            for (int i = 0; i < NE; i++)
            begin
                b_m_reg[i][0] <= PW'(a_a1_reg) * PW'(a_dpy_reg[i]);
                b_m_reg[i][1] <= PW'(a_b1_reg) * PW'(a_dpx_reg[i]);
                b_m_reg[i][2] <= PW'(a_a1_reg) * PW'(a_dqy_reg[i]);
                b_m_reg[i][3] <= PW'(a_b1_reg) * PW'(a_dqx_reg[i]);
                b_m_reg[i][4] <= PW'(a_eb_reg[i]) * PW'(a_dpx_reg[i]);
                b_m_reg[i][5] <= PW'(a_ea_reg[i]) * PW'(a_dpy_reg[i]);
                b_m_reg[i][6] <= PW'(a_ea_reg[i]) * PW'(a_t1y_reg[i]);
                b_m_reg[i][7] <= PW'(a_eb_reg[i]) * PW'(a_t1x_reg[i]);
            end
            b_cm_reg[clipseg_pkg::EDGE_LEFT]  <= PW'(a_b1_reg) * PW'(x_min_reg);
            b_cm_reg[clipseg_pkg::EDGE_RIGHT] <= PW'(a_b1_reg) * PW'(x_max_reg);
            b_cm_reg[clipseg_pkg::EDGE_TOP]   <= PW'(a_a1_reg) * PW'(y_min_reg);
            b_cm_reg[clipseg_pkg::EDGE_BOT]   <= PW'(a_a1_reg) * PW'(y_max_reg);
        end
    end

    // stage C: straddle tests and crossing numerators
    logic signed [NW-1:0] c_f1;
    logic signed [NW-1:0] c_z [NE][4];
    logic [NE-1:0]        c_strad_next, c_fault_next;
    logic signed [NW-1:0] c_num_next [NE];

    always_comb
    begin
        c_f1 = NW'(b_p12_reg) - NW'(b_p03_reg);
        for (int i = 0; i < NE; i++)
        begin
            c_z[i][0] = NW'(b_m_reg[i][0]) - NW'(b_m_reg[i][1]);
            c_z[i][1] = NW'(b_m_reg[i][2]) - NW'(b_m_reg[i][3]);
            c_z[i][2] = NW'(b_m_reg[i][4]) - NW'(b_m_reg[i][5]);
            c_z[i][3] = NW'(b_m_reg[i][6]) - NW'(b_m_reg[i][7]);
            c_strad_next[i] = (c_z[i][0][NW-1] != c_z[i][1][NW-1]) &&
                              (c_z[i][2][NW-1] != c_z[i][3][NW-1]);
            if (i < 2)
            begin
                c_num_next[i]   = c_f1 - NW'(b_cm_reg[i]);
                c_fault_next[i] = (y_max_reg == y_min_reg) || (b_a1_reg == '0);
            end
            else
            begin
                c_num_next[i]   = NW'(b_cm_reg[i]) - c_f1;
                c_fault_next[i] = (x_max_reg == x_min_reg) || (b_b1_reg == '0);
            end
        end
    end

    logic signed [N-1:0]  c_s_reg [4];
    logic                 c_rej_reg, c_in0_reg, c_inb_reg;
    logic signed [W1-1:0] c_a1_reg, c_b1_reg;
    logic [NE-1:0]        c_strad_reg, c_fault_reg;
    logic signed [NW-1:0] c_num_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c_s_reg     <= b_s_reg;
            c_rej_reg   <= b_rej_reg;
            c_in0_reg   <= b_in0_reg;
            c_inb_reg   <= b_inb_reg;
            c_a1_reg    <= b_a1_reg;
            c_b1_reg    <= b_b1_reg;
            c_strad_reg <= c_strad_next;
            c_fault_reg <= c_fault_next;
            c_num_reg   <= c_num_next;
        end
    end

    // stage D: pick the first two crossings, set up the division
    logic [1:0]           d_found;
    logic                 d_stop, d_flt;
    logic [NE-1:0]        d_sel [2];
    logic signed [NW-1:0] d_num;
    logic signed [W1-1:0] d_div;
    logic signed [N-1:0]  e_c [NE];
    dv_t                  d_next;

    always_comb
    begin
        d_found = '0;
        d_stop  = 1'b0;
        d_flt   = 1'b0;
        d_sel[0] = '0;
        d_sel[1] = '0;
        for (int i = 0; i < NE; i++)
        begin
            if (!d_stop && c_strad_reg[i])
            begin
                if (c_fault_reg[i])
                begin
                    d_flt  = 1'b1;
                    d_stop = 1'b1;
                end
                else
                begin
                    d_sel[d_found[0]][i] = 1'b1;
                    d_found = d_found + 2'd1;
                    d_stop  = d_found[1];
                end
            end
        end

        e_c[clipseg_pkg::EDGE_LEFT]  = x_min_reg;
        e_c[clipseg_pkg::EDGE_RIGHT] = x_max_reg;
        e_c[clipseg_pkg::EDGE_TOP]   = y_min_reg;
        e_c[clipseg_pkg::EDGE_BOT]   = y_max_reg;

        d_next     = '0;
        d_next.sx0 = c_s_reg[0];
        d_next.sy0 = c_s_reg[1];
        d_next.sx1 = c_s_reg[2];
        d_next.sy1 = c_s_reg[3];
        d_next.one_cross = (d_found == 2'd1);
        d_next.use_end   = !c_in0_reg;
        if (c_rej_reg)
            d_next.status = clipseg_pkg::ST_REJECTED;
        else if (c_inb_reg)
            d_next.status = clipseg_pkg::ST_INSIDE;
        else if (d_flt || d_found == 2'd0)
            d_next.status = clipseg_pkg::ST_FAULT;
        else
            d_next.status = clipseg_pkg::ST_CLIPPED;

        for (int j = 0; j < 2; j++)
        begin
            d_num = '0;
            for (int i = 0; i < NE; i++)
            begin
                if (d_sel[j][i])
                begin
                    d_num = c_num_reg[i];
                    d_next.cval[j] = e_c[i];
                end
            end
            d_next.vert[j] = |d_sel[j][1:0];
            d_div = d_next.vert[j] ? c_a1_reg : -c_b1_reg;
            d_next.neg[j] = d_num[NW-1] ^ d_div[W1-1];
            d_next.rem[j] = d_num[NW-1] ? NW'(-d_num) : NW'(d_num);
            d_next.dsr[j] = d_div[W1-1] ? W1'(-d_div) : W1'(d_div);
        end
    end

    // divider pipeline: one quotient bit per stage, most significant first
    dv_t dv_reg [Q+1];

    always_ff @(posedge clk)
    begin
        if (adv[3])
            dv_reg[0] <= d_next;
    end

    for (genvar k = 1; k <= Q; k++)
    begin : g_div
        localparam int B = Q - k;
        dv_t           dv_next;
        logic [NW-1:0] dv_sub;

        always_comb
        begin
            dv_next = dv_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                dv_sub = NW'(dv_reg[k-1].dsr[j]) << B;
                if (dv_reg[k-1].rem[j] >= dv_sub)
                begin
                    dv_next.rem[j]    = dv_reg[k-1].rem[j] - dv_sub;
                    dv_next.quo[j][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[3+k])
                dv_reg[k] <= dv_next;
        end
    end

    // output stage
    logic [1:0][N-1:0]  o_val, o_x, o_y;
    logic [W1-1:0]      o_mag;
    logic [N-1:0]       o_sx_next, o_sy_next, o_ex_next, o_ey_next;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            o_mag    = dv_reg[Q].quo[j];
            o_val[j] = dv_reg[Q].neg[j] ? N'(-o_mag) : N'(o_mag);
            o_x[j]   = dv_reg[Q].vert[j] ? dv_reg[Q].cval[j] : o_val[j];
            o_y[j]   = dv_reg[Q].vert[j] ? o_val[j] : dv_reg[Q].cval[j];
        end
        o_sx_next = dv_reg[Q].sx0;
        o_sy_next = dv_reg[Q].sy0;
        o_ex_next = dv_reg[Q].sx1;
        o_ey_next = dv_reg[Q].sy1;
        if (dv_reg[Q].status == clipseg_pkg::ST_CLIPPED)
        begin
            if (dv_reg[Q].one_cross)
            begin
                if (dv_reg[Q].use_end)
                begin
                    o_sx_next = dv_reg[Q].sx1;
                    o_sy_next = dv_reg[Q].sy1;
                end
                o_ex_next = o_x[0];
                o_ey_next = o_y[0];
            end
            else
            begin
                o_sx_next = o_x[0];
                o_sy_next = o_y[0];
                o_ex_next = o_x[1];
                o_ey_next = o_y[1];
            end
        end
    end

    logic [N-1:0]         out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;
    clipseg_pkg::status_t out_status_reg;

    always_ff @(posedge clk)
    begin
        if (adv[L-1])
        begin
            out_sx_reg     <= o_sx_next;
            out_sy_reg     <= o_sy_next;
            out_ex_reg     <= o_ex_next;
            out_ey_reg     <= o_ey_next;
            out_status_reg <= dv_reg[Q].status;
        end
    end

    assign clipped.valid       = vld_reg[L-1];
    assign clipped.out_start_x = out_sx_reg;
    assign clipped.out_start_y = out_sy_reg;
    assign clipped.out_end_x   = out_ex_reg;
    assign clipped.out_end_y   = out_ey_reg;
    assign clipped.status      = out_status_reg;

`ifndef SYNTHESIS
    a_clip_has_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && dv_reg[0].status == clipseg_pkg::ST_CLIPPED |-> dv_reg[0].dsr[0] != '0)
        else $error("clipped item with zero divisor");

    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3+Q] && dv_reg[Q].status == clipseg_pkg::ST_CLIPPED
        |-> dv_reg[Q].rem[0] < NW'(dv_reg[Q].dsr[0]))
        else $error("division remainder not below divisor");

    a_quo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3+Q] && dv_reg[Q].status == clipseg_pkg::ST_CLIPPED
        |-> dv_reg[Q].quo[0] <= (W1'(1) << (N - 1)))
        else $error("crossing coordinate outside coordinate range");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[L-2] && !adv[L-2] |=> vld_reg[L-2] && vld_reg[L-1])
        else $error("item dropped while output blocked");
`endif

endmodule

// ===== dv/clip_segment_to_rectangle_tb.sv =====
`timescale 1ns / 100ps

module clip_segment_to_rectangle_tb;

    localparam int CW = 16;
    localparam int LATENCY = CW + 5;
    localparam int HOLD_OFF_LEN = 200;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        clipseg_pkg::status_t st;
    } clip_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [clipseg_pkg::CFG_IDX_BITS-1:0] wr_index = '0;
    logic [CW-1:0] wr_data = '0;

    clipseg_seg_if #(.W(CW)) segment ();
    clipseg_res_if #(.W(CW)) clipped ();

    clip_segment_to_rectangle #(.COORD_BITS(CW)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .segment  (segment),
        .clipped  (clipped),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #6 clk = ~clk;

    longint win_x_min, win_x_max, win_y_min, win_y_max;
    clip_res_t expected_clips[$];
    int mismatch_count = 0;
    bit send_idle_en = 1'b0;
    bit recv_idle_en = 1'b0;
    bit hold_off_go = 1'b0;
    int hold_off_cycles = 0;

    function automatic bit opposite_sign(longint z1, longint z2);
        return (z1 < 0) ? (z2 >= 0) : (z2 < 0);
    endfunction

    function automatic longint side_of(longint ox, longint oy, longint a, longint b,
                                       longint px, longint py);
        return a * (oy - py) - b * (px - ox);
    endfunction

    function automatic bit seg_straddles(longint s[4], longint e[4]);
        longint a1, b1, a2, b2;
        a1 = s[2] - s[0];
        b1 = s[1] - s[3];
        a2 = e[2] - e[0];
        b2 = e[1] - e[3];
        if (!opposite_sign(side_of(s[0], s[1], a1, b1, e[0], e[1]),
                           side_of(s[0], s[1], a1, b1, e[2], e[3])))
            return 1'b0;
        return opposite_sign(side_of(e[0], e[1], a2, b2, s[0], s[1]),
                             side_of(e[0], e[1], a2, b2, s[2], s[3]));
    endfunction

    function automatic bit strictly_in(longint x, longint y);
        return x > win_x_min && x < win_x_max && y > win_y_min && y < win_y_max;
    endfunction

    function automatic clip_res_t clip_segment(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                                               logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
        longint s[4];
        longint r[4];
        longint e[4];
        longint cx[2], cy[2];
        longint d1, e1, f1, c;
        int found;
        bit fault;
        clip_res_t res;
        s[0] = sx; s[1] = sy; s[2] = ex; s[3] = ey;
        r = s;
        found = 0;
        fault = 1'b0;
        if ((s[0] <= win_x_min && s[2] <= win_x_min) || (s[0] >= win_x_max && s[2] >= win_x_max) ||
            (s[1] <= win_y_min && s[3] <= win_y_min) || (s[1] >= win_y_max && s[3] >= win_y_max))
        begin
            res.st = clipseg_pkg::ST_REJECTED;
        end
        else if (strictly_in(s[0], s[1]) && strictly_in(s[2], s[3]))
        begin
            res.st = clipseg_pkg::ST_INSIDE;
        end
        else
        begin
            d1 = s[3] - s[1];
            e1 = s[0] - s[2];
            f1 = s[1] * s[2] - s[0] * s[3];
            for (int i = 0; i < clipseg_pkg::NUM_EDGES && found < 2 && !fault; i++)
            begin
                case (i)
                    clipseg_pkg::EDGE_LEFT:
                        e = '{win_x_min, win_y_min, win_x_min, win_y_max};
                    clipseg_pkg::EDGE_RIGHT:
                        e = '{win_x_max, win_y_min, win_x_max, win_y_max};
                    clipseg_pkg::EDGE_TOP:
                        e = '{win_x_min, win_y_min, win_x_max, win_y_min};
                    default:
                        e = '{win_x_min, win_y_max, win_x_max, win_y_max};
                endcase
                if (seg_straddles(s, e))
                begin
                    if (i == clipseg_pkg::EDGE_LEFT || i == clipseg_pkg::EDGE_RIGHT)
                    begin
                        c = e[0];
                        if (e[3] - e[1] == 0 || e1 == 0)
                            fault = 1'b1;
                        else
                        begin
                            cx[found] = c;
                            cy[found] = (f1 + d1 * c) / (0 - e1);
                            found++;
                        end
                    end
                    else
                    begin
                        c = e[1];
                        if (e[0] - e[2] == 0 || d1 == 0)
                            fault = 1'b1;
                        else
                        begin
                            cx[found] = (0 - (e1 * c + f1)) / d1;
                            cy[found] = c;
                            found++;
                        end
                    end
                end
            end
            if (fault || found == 0)
                res.st = clipseg_pkg::ST_FAULT;
            else if (found == 2)
            begin
                r = '{cx[0], cy[0], cx[1], cy[1]};
                res.st = clipseg_pkg::ST_CLIPPED;
            end
            else
            begin
                if (!strictly_in(s[0], s[1]))
                begin
                    r[0] = s[2];
                    r[1] = s[3];
                end
                r[2] = cx[0];
                r[3] = cy[0];
                res.st = clipseg_pkg::ST_CLIPPED;
            end
        end
        res.sx = r[0][CW-1:0];
        res.sy = r[1][CW-1:0];
        res.ex = r[2][CW-1:0];
        res.ey = r[3][CW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic write_window(clipseg_pkg::cfg_reg_t idx, logic signed [CW-1:0] value);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            clipseg_pkg::REG_X_MIN: win_x_min = value;
            clipseg_pkg::REG_X_MAX: win_x_max = value;
            clipseg_pkg::REG_Y_MIN: win_y_min = value;
            default:                win_y_max = value;
        endcase
    endtask

    task automatic set_window(int x0, int x1, int y0, int y1);
        write_window(clipseg_pkg::REG_X_MIN, CW'(x0));
        write_window(clipseg_pkg::REG_X_MAX, CW'(x1));
        write_window(clipseg_pkg::REG_Y_MIN, CW'(y0));
        write_window(clipseg_pkg::REG_Y_MAX, CW'(y1));
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_segment(int sx, int sy, int ex, int ey);
        while (send_idle_en && $urandom_range(99) < 21)
        begin
            segment.valid <= 1'b0;
            @(negedge clk);
        end
        segment.valid <= 1'b1;
        segment.start_x <= CW'(sx);
        segment.start_y <= CW'(sy);
        segment.end_x <= CW'(ex);
        segment.end_y <= CW'(ey);
        do
            @(posedge clk);
        while (!segment.ready);
        expected_clips = {expected_clips, clip_segment(CW'(sx), CW'(sy), CW'(ex), CW'(ey))};
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        segment.valid <= 1'b0;
        while (expected_clips.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic signed [CW-1:0] pick_coord(int lo, int hi);
        case ($urandom_range(9))
            0: return CW'($urandom);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return CW'(lo + int'($urandom_range(hi - lo)));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CW-1:0] ext[4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        send_segment(10, 10, 500, 600);
        send_segment(-50, 100, 2000, 900);
        send_segment(-50, 500, 500, 500);
        send_segment(500, -50, 500, 2000);
        send_segment(-10, -10, -5, 2000);
        send_segment(0, 0, 1023, 1023);
        send_segment(0, 500, 1023, 500);
        send_segment(500, 500, 1023, 1023);
        send_segment(500, 500, 1023, 500);
        send_segment(-100, 1100, 1100, -100);
        send_segment(100, -1, -1, 100);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 2; j++)
                send_segment(ext[i], ext[(i + 1) % 4], ext[(i + 2 + j) % 4], ext[3 - i]);
        send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
    endtask

    task automatic test_random(int count, int lo, int hi);
        for (int n = 0; n < count; n++)
            send_segment(pick_coord(lo, hi), pick_coord(lo, hi),
                         pick_coord(lo, hi), pick_coord(lo, hi));
    endtask

    task automatic test_windows();
        set_window(-32768, 32767, -32768, 32767);
        test_random(150, -32768, 32767);
        drain();
        set_window(200, 200, -300, 400);
        test_random(150, -500, 800);
        drain();
        set_window(500, -500, 300, -300);
        test_random(150, -800, 800);
        drain();
        set_window(-1000, 3000, -20000, -19000);
        test_random(200, -22000, 4000);
        drain();
        set_window(-8, 8, -8, 8);
        test_random(200, -20, 20);
        drain();
        set_window(32767, -32768, 32767, -32768);
        test_random(60, -32768, 32767);
        drain();
        set_window(0, 1023, 0, 1023);
    endtask

    task automatic test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        hold_off_go = 1'b1;
        test_random(260, -200, 1200);
        drain();
    endtask

    always @(posedge clk)
    begin
        clip_res_t want;
        if (clipped.valid && clipped.ready)
        begin
            if (expected_clips.size() == 0)
            begin
                report_mismatch("unexpected item status", clipped.status, 0);
            end
            else
            begin
                want = expected_clips.pop_front();
                if (clipped.out_start_x !== want.sx)
                    report_mismatch("out_start_x", clipped.out_start_x, want.sx);
                if (clipped.out_start_y !== want.sy)
                    report_mismatch("out_start_y", clipped.out_start_y, want.sy);
                if (clipped.out_end_x !== want.ex)
                    report_mismatch("out_end_x", clipped.out_end_x, want.ex);
                if (clipped.out_end_y !== want.ey)
                    report_mismatch("out_end_y", clipped.out_end_y, want.ey);
                if (clipped.status !== want.st)
                    report_mismatch("status", clipped.status, want.st);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_go && hold_off_cycles < HOLD_OFF_LEN)
        begin
            clipped.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles + 1;
        end
        else
            clipped.ready <= !(recv_idle_en && $urandom_range(99) < 21);
    end

    initial
    begin
        segment.valid = 1'b0;
        segment.start_x = '0;
        segment.start_y = '0;
        segment.end_x = '0;
        segment.end_y = '0;
        win_x_min = 0;
        win_x_max = 1023;
        win_y_min = 0;
        win_y_max = 1023;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        test_random(300, -300, 1400);
        drain();
        test_windows();
        test_backpressure();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        test_random(300, -200, 1200);
        drain();
        if (mismatch_count == 0 && expected_clips.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/clipseg_pkg.sv
sv/clipseg_seg_if.sv
sv/clipseg_res_if.sv
sv/clip_segment_to_rectangle.sv
dv/clip_segment_to_rectangle_tb.sv
